[sv/tlsm_pkg.sv]
// Package for the transfer latency statistics monitor.
// Holds the event kinds, statistic and register indexes, widths and the request word type.
// No dependencies; every other file of the block uses it.
package tlsm_pkg;

   localparam int KIND_WIDTH  = 4;
   localparam int TIME_WIDTH  = 48;
   localparam int EDGE_WIDTH  = 24;
   localparam int INDEX_WIDTH = 6;
   localparam int DATA_WIDTH  = 64;
   localparam int SUM_WIDTH   = 64;
   localparam int SNAP_WIDTH  = 8;
   localparam int BYTE_WIDTH  = 16;

   // Event kinds carried by a request word.
   localparam logic [KIND_WIDTH-1:0] KIND_INIT         = 4'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_BUSY         = 4'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_START        = 4'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_START_ERR    = 4'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_COMPLETE     = 4'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_COMPLETE_ERR = 4'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_ZLP          = 4'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_ZLP_ERR      = 4'd7;
   localparam logic [KIND_WIDTH-1:0] KIND_SAMPLE       = 4'd8;
   localparam logic [KIND_WIDTH-1:0] KIND_READ         = 4'd9;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_MID  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_HIGH = 2'd2;
   localparam logic [EDGE_WIDTH-1:0] EDGE_LOW_RESET  = 24'd1000;
   localparam logic [EDGE_WIDTH-1:0] EDGE_MID_RESET  = 24'd5000;
   localparam logic [EDGE_WIDTH-1:0] EDGE_HIGH_RESET = 24'd25000;

   // Event counter slots.
   localparam int NUM_COUNTERS     = 17;
   localparam int CNT_SAMPLES      = 0;
   localparam int CNT_INITS        = 1;
   localparam int CNT_BUSY         = 2;
   localparam int CNT_BUSY_NO_FREE = 3;
   localparam int CNT_BUSY_ACTIVE  = 4;
   localparam int CNT_STARTED      = 5;
   localparam int CNT_START_ERR    = 6;
   localparam int CNT_COMPLETED    = 7;
   localparam int CNT_COMPLETE_ERR = 8;
   localparam int CNT_ZLP          = 9;
   localparam int CNT_ZLP_ERR      = 10;
   localparam int CNT_GAPS         = 11;
   localparam int CNT_TIMED        = 12;
   localparam int CNT_BUCKET0      = 13;
   localparam int CNT_BUCKET1      = 14;
   localparam int CNT_BUCKET2      = 15;
   localparam int CNT_BUCKET3      = 16;
   localparam int CNT_SEL_WIDTH    = 5;

   // Running sum slots.
   localparam int NUM_SUMS          = 5;
   localparam int SUM_BYTES_STARTED = 0;
   localparam int SUM_FRAMES_STARTED = 1;
   localparam int SUM_BYTES_DONE    = 2;
   localparam int SUM_LATENCY       = 3;
   localparam int SUM_GAP           = 4;
   localparam int SUM_SEL_WIDTH     = 3;

   // Latency buckets.
   localparam logic [1:0] BUCKET_LOW  = 2'd0;
   localparam logic [1:0] BUCKET_MID  = 2'd1;
   localparam logic [1:0] BUCKET_HIGH = 2'd2;
   localparam logic [1:0] BUCKET_OVER = 2'd3;

   // Statistic indexes for a read word.
   localparam logic [INDEX_WIDTH-1:0] STAT_SEEN       = 6'd0;
   localparam logic [INDEX_WIDTH-1:0] STAT_FREE_MIN   = 6'd1;
   localparam logic [INDEX_WIDTH-1:0] STAT_READY_MAX  = 6'd2;
   localparam logic [INDEX_WIDTH-1:0] STAT_LAST_TIME  = 6'd3;
   localparam logic [INDEX_WIDTH-1:0] STAT_SNAP_FREE  = 6'd4;
   localparam logic [INDEX_WIDTH-1:0] STAT_SNAP_READY = 6'd5;
   localparam logic [INDEX_WIDTH-1:0] STAT_SNAP_ACT   = 6'd6;
   localparam logic [INDEX_WIDTH-1:0] STAT_SNAP_GLUE  = 6'd7;
   localparam logic [INDEX_WIDTH-1:0] STAT_SNAP_GFR   = 6'd8;
   localparam logic [INDEX_WIDTH-1:0] STAT_CNT_FIRST  = 6'd9;
   localparam logic [INDEX_WIDTH-1:0] STAT_CNT_LAST   = 6'd25;
   localparam logic [INDEX_WIDTH-1:0] STAT_SUM_FIRST  = 6'd26;
   localparam logic [INDEX_WIDTH-1:0] STAT_SUM_LAST   = 6'd30;
   localparam logic [INDEX_WIDTH-1:0] STAT_LAT_MAX    = 6'd31;
   localparam logic [INDEX_WIDTH-1:0] STAT_GAP_MAX    = 6'd32;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [TIME_WIDTH-1:0]  time_us;
      logic [SNAP_WIDTH-1:0]  free_buffers;
      logic [SNAP_WIDTH-1:0]  ready_buffers;
      logic                   transfer_active;
      logic                   glue_present;
      logic [SNAP_WIDTH-1:0]  glue_frame_count;
      logic [BYTE_WIDTH-1:0]  byte_count;
      logic [BYTE_WIDTH-1:0]  frame_count;
      logic [INDEX_WIDTH-1:0] counter_index;
   } req_item_type;

   typedef struct packed {
      logic [EDGE_WIDTH-1:0] low;
      logic [EDGE_WIDTH-1:0] mid;
      logic [EDGE_WIDTH-1:0] high;
   } edges_type;

endpackage

[sv/tlsm_req_if.sv]
// Request channel of the transfer latency statistics monitor: valid, ready and one event word.
// Depends on tlsm_pkg for the field widths.
interface tlsm_req_if;
   logic                             valid;
   logic                             ready;
   logic [tlsm_pkg::KIND_WIDTH-1:0]  kind;
   logic [tlsm_pkg::TIME_WIDTH-1:0]  time_us;
   logic [tlsm_pkg::SNAP_WIDTH-1:0]  free_buffers;
   logic [tlsm_pkg::SNAP_WIDTH-1:0]  ready_buffers;
   logic                             transfer_active;
   logic                             glue_present;
   logic [tlsm_pkg::SNAP_WIDTH-1:0]  glue_frame_count;
   logic [tlsm_pkg::BYTE_WIDTH-1:0]  byte_count;
   logic [tlsm_pkg::BYTE_WIDTH-1:0]  frame_count;
   logic [tlsm_pkg::INDEX_WIDTH-1:0] counter_index;

   modport source (
      output valid, kind, time_us, free_buffers, ready_buffers, transfer_active,
             glue_present, glue_frame_count, byte_count, frame_count, counter_index,
      input  ready
   );
   modport sink (
      input  valid, kind, time_us, free_buffers, ready_buffers, transfer_active,
             glue_present, glue_frame_count, byte_count, frame_count, counter_index,
      output ready
   );
endinterface

[sv/tlsm_rsp_if.sv]
// Response channel of the transfer latency statistics monitor: valid, ready and read data.
// Depends on tlsm_pkg for the data width.
interface tlsm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tlsm_pkg::DATA_WIDTH-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

[sv/tlsm_bucket.sv]
// Latency bucket classifier: compares one elapsed time against the three configured edges.
// Depends on tlsm_pkg for widths and bucket codes.
module tlsm_bucket (
   input  logic [tlsm_pkg::TIME_WIDTH-1:0] elapsed,
   input  tlsm_pkg::edges_type             edges,
   output logic [1:0]                      bucket
);

   // The three compares run in parallel; the priority picks the lowest matching edge.
   always_comb begin
      if (elapsed <= tlsm_pkg::TIME_WIDTH'(edges.low)) begin
         bucket = tlsm_pkg::BUCKET_LOW;
      end else if (elapsed <= tlsm_pkg::TIME_WIDTH'(edges.mid)) begin
         bucket = tlsm_pkg::BUCKET_MID;
      end else if (elapsed <= tlsm_pkg::TIME_WIDTH'(edges.high)) begin
         bucket = tlsm_pkg::BUCKET_HIGH;
      end else begin
         bucket = tlsm_pkg::BUCKET_OVER;
      end
   end

endmodule

[sv/tlsm_stats.sv]
// Statistics state of the monitor: updates every counter, sum, maximum and timer for one
// event word per cycle and selects a statistic for a read. Depends on tlsm_pkg, tlsm_bucket.
module tlsm_stats #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            upd_en,
   input  tlsm_pkg::req_item_type          item,
   input  tlsm_pkg::edges_type             edges,
   output logic [tlsm_pkg::DATA_WIDTH-1:0] read_data
);

   localparam int TW = tlsm_pkg::TIME_WIDTH;
   localparam int SW = tlsm_pkg::SUM_WIDTH;
   localparam int NC = tlsm_pkg::NUM_COUNTERS;
   localparam int NS = tlsm_pkg::NUM_SUMS;

   logic                          seen_ff, seen_in;
   logic [tlsm_pkg::SNAP_WIDTH-1:0] free_min_ff, free_min_in;
   logic [tlsm_pkg::SNAP_WIDTH-1:0] ready_max_ff, ready_max_in;
   logic [TW-1:0]                 last_time_ff, last_time_in;
   logic [tlsm_pkg::SNAP_WIDTH-1:0] snap_free_ff, snap_free_in;
   logic [tlsm_pkg::SNAP_WIDTH-1:0] snap_ready_ff, snap_ready_in;
   logic                          snap_act_ff, snap_act_in;
   logic                          snap_glue_ff, snap_glue_in;
   logic [tlsm_pkg::SNAP_WIDTH-1:0] snap_gfr_ff, snap_gfr_in;
   logic [COUNTER_WIDTH-1:0]      counters_ff [NC];
   logic [SW-1:0]                 sums_ff [NS];
   logic [SW-1:0]                 sums_in [NS];
   logic [TW-1:0]                 lat_max_ff, lat_max_in;
   logic [TW-1:0]                 gap_max_ff, gap_max_in;
   logic                          comp_timing_ff, comp_timing_in;
   logic                          backlog_timing_ff, backlog_timing_in;
   logic [TW-1:0]                 start_time_ff, start_time_in;
   logic [TW-1:0]                 backlog_start_ff, backlog_start_in;

   logic [NC-1:0]                 bump;
   logic                          record;
   logic [TW-1:0]                 elapsed;
   logic [TW-1:0]                 gap;
   logic [1:0]                    bucket;
   logic [tlsm_pkg::INDEX_WIDTH-1:0] cnt_off;
   logic [tlsm_pkg::INDEX_WIDTH-1:0] sum_off;

   // Differences wrap modulo the timestamp width.
   assign elapsed = item.time_us - start_time_ff;
   assign gap     = item.time_us - backlog_start_ff;
   assign record  = upd_en && (item.kind <= tlsm_pkg::KIND_SAMPLE);

   tlsm_bucket u_bucket (
      .elapsed (elapsed),
      .edges   (edges),
      .bucket  (bucket)
   );

   always_comb begin
      seen_in           = seen_ff;
      free_min_in       = free_min_ff;
      ready_max_in      = ready_max_ff;
      last_time_in      = last_time_ff;
      snap_free_in      = snap_free_ff;
      snap_ready_in     = snap_ready_ff;
      snap_act_in       = snap_act_ff;
      snap_glue_in      = snap_glue_ff;
      snap_gfr_in       = snap_gfr_ff;
      sums_in           = sums_ff;
      lat_max_in        = lat_max_ff;
      gap_max_in        = gap_max_ff;
      comp_timing_in    = comp_timing_ff;
      backlog_timing_in = backlog_timing_ff;
      start_time_in     = start_time_ff;
      backlog_start_in  = backlog_start_ff;
      bump              = '0;
      if (record) begin
         if (!seen_ff || (item.free_buffers < free_min_ff)) begin
            free_min_in = item.free_buffers;
         end
         if (item.ready_buffers > ready_max_ff) begin
            ready_max_in = item.ready_buffers;
         end
         seen_in                        = 1'b1;
         last_time_in                   = item.time_us;
         bump[tlsm_pkg::CNT_SAMPLES]    = 1'b1;
         snap_free_in                   = item.free_buffers;
         snap_ready_in                  = item.ready_buffers;
         snap_act_in                    = item.transfer_active;
         snap_glue_in                   = item.glue_present;
         snap_gfr_in                    = item.glue_frame_count;
         unique case (item.kind)
            tlsm_pkg::KIND_INIT: begin
               bump[tlsm_pkg::CNT_INITS] = 1'b1;
               comp_timing_in    = 1'b0;
               backlog_timing_in = 1'b0;
            end
            tlsm_pkg::KIND_BUSY: begin
               bump[tlsm_pkg::CNT_BUSY]         = 1'b1;
               bump[tlsm_pkg::CNT_BUSY_NO_FREE] = (item.free_buffers == '0);
               bump[tlsm_pkg::CNT_BUSY_ACTIVE]  = item.transfer_active;
            end
            tlsm_pkg::KIND_START: begin
               bump[tlsm_pkg::CNT_STARTED] = 1'b1;
               sums_in[tlsm_pkg::SUM_BYTES_STARTED] =
                  sums_ff[tlsm_pkg::SUM_BYTES_STARTED] + SW'(item.byte_count);
               sums_in[tlsm_pkg::SUM_FRAMES_STARTED] =
                  sums_ff[tlsm_pkg::SUM_FRAMES_STARTED] + SW'(item.frame_count);
               comp_timing_in = 1'b1;
               start_time_in  = item.time_us;
               // A start closes an open backlog gap.
               if (backlog_timing_ff) begin
                  bump[tlsm_pkg::CNT_GAPS] = 1'b1;
                  sums_in[tlsm_pkg::SUM_GAP] = sums_ff[tlsm_pkg::SUM_GAP] + SW'(gap);
                  if (gap > gap_max_ff) begin
                     gap_max_in = gap;
                  end
                  backlog_timing_in = 1'b0;
               end
            end
            tlsm_pkg::KIND_START_ERR: begin
               bump[tlsm_pkg::CNT_START_ERR] = 1'b1;
            end
            tlsm_pkg::KIND_COMPLETE, tlsm_pkg::KIND_COMPLETE_ERR: begin
               if (item.kind == tlsm_pkg::KIND_COMPLETE) begin
                  bump[tlsm_pkg::CNT_COMPLETED] = 1'b1;
                  sums_in[tlsm_pkg::SUM_BYTES_DONE] =
                     sums_ff[tlsm_pkg::SUM_BYTES_DONE] + SW'(item.byte_count);
               end else begin
                  bump[tlsm_pkg::CNT_COMPLETE_ERR] = 1'b1;
               end
               // Only a completion that follows a start is timed.
               if (comp_timing_ff) begin
                  bump[tlsm_pkg::CNT_TIMED] = 1'b1;
                  sums_in[tlsm_pkg::SUM_LATENCY] =
                     sums_ff[tlsm_pkg::SUM_LATENCY] + SW'(elapsed);
                  if (elapsed > lat_max_ff) begin
                     lat_max_in = elapsed;
                  end
                  bump[tlsm_pkg::CNT_BUCKET0] = (bucket == tlsm_pkg::BUCKET_LOW);
                  bump[tlsm_pkg::CNT_BUCKET1] = (bucket == tlsm_pkg::BUCKET_MID);
                  bump[tlsm_pkg::CNT_BUCKET2] = (bucket == tlsm_pkg::BUCKET_HIGH);
                  bump[tlsm_pkg::CNT_BUCKET3] = (bucket == tlsm_pkg::BUCKET_OVER);
               end
               comp_timing_in    = 1'b0;
               backlog_timing_in = (item.ready_buffers != '0) ||
                                   (item.glue_present && (item.glue_frame_count != '0));
               backlog_start_in  = item.time_us;
            end
            tlsm_pkg::KIND_ZLP: begin
               bump[tlsm_pkg::CNT_ZLP] = 1'b1;
            end
            tlsm_pkg::KIND_ZLP_ERR: begin
               bump[tlsm_pkg::CNT_ZLP_ERR] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff           <= 1'b0;
         free_min_ff       <= '0;
         ready_max_ff      <= '0;
         last_time_ff      <= '0;
         snap_free_ff      <= '0;
         snap_ready_ff     <= '0;
         snap_act_ff       <= 1'b0;
         snap_glue_ff      <= 1'b0;
         snap_gfr_ff       <= '0;
         lat_max_ff        <= '0;
         gap_max_ff        <= '0;
         comp_timing_ff    <= 1'b0;
         backlog_timing_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            counters_ff[i] <= '0;
         end
         for (int i = 0; i < NS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         seen_ff           <= seen_in;
         free_min_ff       <= free_min_in;
         ready_max_ff      <= ready_max_in;
         last_time_ff      <= last_time_in;
         snap_free_ff      <= snap_free_in;
         snap_ready_ff     <= snap_ready_in;
         snap_act_ff       <= snap_act_in;
         snap_glue_ff      <= snap_glue_in;
         snap_gfr_ff       <= snap_gfr_in;
         lat_max_ff        <= lat_max_in;
         gap_max_ff        <= gap_max_in;
         comp_timing_ff    <= comp_timing_in;
         backlog_timing_ff <= backlog_timing_in;
         for (int i = 0; i < NC; i++) begin
            if (bump[i]) begin
               counters_ff[i] <= counters_ff[i] + COUNTER_WIDTH'(1);
            end
         end
         sums_ff <= sums_in;
      end
   end

   // Timer origins are only read while their timer is armed.
   always_ff @(posedge clock) begin
      start_time_ff    <= start_time_in;
      backlog_start_ff <= backlog_start_in;
   end

   assign cnt_off = item.counter_index - tlsm_pkg::STAT_CNT_FIRST;
   assign sum_off = item.counter_index - tlsm_pkg::STAT_SUM_FIRST;

   always_comb begin
      unique case (item.counter_index) inside
         tlsm_pkg::STAT_SEEN:       read_data = tlsm_pkg::DATA_WIDTH'(seen_ff);
         tlsm_pkg::STAT_FREE_MIN:   read_data = tlsm_pkg::DATA_WIDTH'(free_min_ff);
         tlsm_pkg::STAT_READY_MAX:  read_data = tlsm_pkg::DATA_WIDTH'(ready_max_ff);
         tlsm_pkg::STAT_LAST_TIME:  read_data = tlsm_pkg::DATA_WIDTH'(last_time_ff);
         tlsm_pkg::STAT_SNAP_FREE:  read_data = tlsm_pkg::DATA_WIDTH'(snap_free_ff);
         tlsm_pkg::STAT_SNAP_READY: read_data = tlsm_pkg::DATA_WIDTH'(snap_ready_ff);
         tlsm_pkg::STAT_SNAP_ACT:   read_data = tlsm_pkg::DATA_WIDTH'(snap_act_ff);
         tlsm_pkg::STAT_SNAP_GLUE:  read_data = tlsm_pkg::DATA_WIDTH'(snap_glue_ff);
         tlsm_pkg::STAT_SNAP_GFR:   read_data = tlsm_pkg::DATA_WIDTH'(snap_gfr_ff);
         [tlsm_pkg::STAT_CNT_FIRST:tlsm_pkg::STAT_CNT_LAST]:
            read_data = tlsm_pkg::DATA_WIDTH'(
               counters_ff[cnt_off[tlsm_pkg::CNT_SEL_WIDTH-1:0]]);
         [tlsm_pkg::STAT_SUM_FIRST:tlsm_pkg::STAT_SUM_LAST]:
            read_data = sums_ff[sum_off[tlsm_pkg::SUM_SEL_WIDTH-1:0]];
         tlsm_pkg::STAT_LAT_MAX:    read_data = tlsm_pkg::DATA_WIDTH'(lat_max_ff);
         tlsm_pkg::STAT_GAP_MAX:    read_data = tlsm_pkg::DATA_WIDTH'(gap_max_ff);
         default:                   read_data = '0;
      endcase
   end

   a_start_arms_timer: assert property (@(posedge clock) disable iff (reset)
      upd_en && (item.kind == tlsm_pkg::KIND_START) |=> comp_timing_ff)
      else $error("start event did not arm the completion timer");

   a_init_disarms: assert property (@(posedge clock) disable iff (reset)
      upd_en && (item.kind == tlsm_pkg::KIND_INIT) |=> !comp_timing_ff && !backlog_timing_ff)
      else $error("init event left a timer armed");

   a_ready_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ready_max_ff >= $past(ready_max_ff))
      else $error("ready maximum decreased");

endmodule

[sv/transfer_latency_stats_monitor.sv]
// Top level of the transfer latency statistics monitor.
// Depends on tlsm_pkg, tlsm_req_if, tlsm_rsp_if, tlsm_stats and tlsm_bucket.

// The monitor takes one event word per clock cycle on the req_bus channel and keeps
// running statistics on it: minimum free and maximum ready buffer counts, the last
// sample time and buffer snapshot, per-kind event counters, byte and frame sums,
// start-to-completion latency (sum, maximum and four buckets whose edges come from the
// csr_ registers) and the backlog gap from a completion that left queued work to the
// next start. A read word (kind 9) returns one statistic, zero-extended to 64 bits, on
// rsp_bus; every other kind returns nothing, and undefined kinds change nothing. An
// accepted word waits in an input register, and as it leaves, its whole update is
// applied to the statistics registers in a single pass, so the following word
// always sees the result of the one before. A read result is taken into an output
// register as the read word leaves the input register. Throughput is one word per
// cycle; req_bus.ready drops only while a read waits in the input register behind a
// response that the consumer has not yet taken. Counters are COUNTER_WIDTH bits wide
// and wrap, sums are 64 bits and wrap, and time differences wrap modulo 2^48. The
// bucket edges should only be written while no word is in flight.
module transfer_latency_stats_monitor #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tlsm_req_if.sink                             req_bus,
   tlsm_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [tlsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tlsm_pkg::EDGE_WIDTH-1:0]      csr_wdata
);

   // Input register holding the accepted word until it is applied.
   logic                   stage_valid_ff;
   tlsm_pkg::req_item_type stage_item_ff;
   tlsm_pkg::req_item_type req_item;

   // Output register for read results.
   logic                            rsp_valid_ff;
   logic [tlsm_pkg::DATA_WIDTH-1:0] rsp_data_ff;

   // Bucket edge registers.
   tlsm_pkg::edges_type edges_ff;

   logic                            stage_is_read;
   logic                            stage_go;
   logic                            req_take;
   logic [tlsm_pkg::DATA_WIDTH-1:0] stat_data;

   assign req_item.kind             = req_bus.kind;
   assign req_item.time_us          = req_bus.time_us;
   assign req_item.free_buffers     = req_bus.free_buffers;
   assign req_item.ready_buffers    = req_bus.ready_buffers;
   assign req_item.transfer_active  = req_bus.transfer_active;
   assign req_item.glue_present     = req_bus.glue_present;
   assign req_item.glue_frame_count = req_bus.glue_frame_count;
   assign req_item.byte_count       = req_bus.byte_count;
   assign req_item.frame_count      = req_bus.frame_count;
   assign req_item.counter_index    = req_bus.counter_index;

   // A staged word moves on unless it is a read and the output register is still full.
   assign stage_is_read = (stage_item_ff.kind == tlsm_pkg::KIND_READ);
   assign stage_go      = stage_valid_ff && (!stage_is_read || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || stage_go;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   tlsm_stats #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (stage_go),
      .item      (stage_item_ff),
      .edges     (edges_ff),
      .read_data (stat_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            stage_valid_ff <= 1'b1;
         end else if (stage_go) begin
            stage_valid_ff <= 1'b0;
         end
         if (stage_go && stage_is_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff <= req_item;
      end
      if (stage_go && stage_is_read) begin
         rsp_data_ff <= stat_data;
      end
   end

   // Configuration writes to an index past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff.low  <= tlsm_pkg::EDGE_LOW_RESET;
         edges_ff.mid  <= tlsm_pkg::EDGE_MID_RESET;
         edges_ff.high <= tlsm_pkg::EDGE_HIGH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tlsm_pkg::CSR_EDGE_LOW:  edges_ff.low  <= csr_wdata;
            tlsm_pkg::CSR_EDGE_MID:  edges_ff.mid  <= csr_wdata;
            tlsm_pkg::CSR_EDGE_HIGH: edges_ff.high <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_valid_ff && stage_is_read))
      else $error("response raised without a staged read word");

   a_stall_only_on_read: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> stage_valid_ff && stage_is_read && rsp_valid_ff && !rsp_bus.ready)
      else $error("request side stalled without a blocked read");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      stage_go && stage_is_read |=> rsp_valid_ff)
      else $error("read word left the input register without a response");

endmodule

[tb/tlsm_checker.sv]
// Scoreboard for the transfer latency statistics monitor: watches both channels and the csr_ port.
// Keeps its own copy of the statistics, predicts each read word's data and compares it.
// Depends on tlsm_pkg, tlsm_req_if and tlsm_rsp_if.
module tlsm_checker
   import tlsm_pkg::*;
#(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   tlsm_req_if                        req_mon,
   tlsm_rsp_if                        rsp_mon,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [EDGE_WIDTH-1:0]      csr_wdata,
   output int                         mismatch_count,
   output int                         reads_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   edges_type                edges;
   logic                     any_recorded;
   logic [SNAP_WIDTH-1:0]    lowest_free;
   logic [SNAP_WIDTH-1:0]    highest_ready;
   logic [TIME_WIDTH-1:0]    last_stamp;
   logic [SNAP_WIDTH-1:0]    snap [5];
   logic [COUNTER_WIDTH-1:0] tallies [NUM_COUNTERS];
   logic [SUM_WIDTH-1:0]     totals [NUM_SUMS];
   logic [TIME_WIDTH-1:0]    worst_latency;
   logic [TIME_WIDTH-1:0]    worst_gap;
   logic                     latency_armed;
   logic                     gap_armed;
   logic [TIME_WIDTH-1:0]    started_at;
   logic [TIME_WIDTH-1:0]    gap_from;
   logic [DATA_WIDTH-1:0]    expected_reads [$];
   int                       mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report(input string what, input logic [DATA_WIDTH-1:0] got,
                         input logic [DATA_WIDTH-1:0] want);
      mismatches++;
      $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   task automatic clear_stats();
      edges         = '{low: EDGE_LOW_RESET, mid: EDGE_MID_RESET, high: EDGE_HIGH_RESET};
      any_recorded  = 1'b0;
      lowest_free   = '0;
      highest_ready = '0;
      last_stamp    = '0;
      foreach (snap[i]) snap[i] = '0;
      foreach (tallies[i]) tallies[i] = '0;
      foreach (totals[i]) totals[i] = '0;
      worst_latency = '0;
      worst_gap     = '0;
      latency_armed = 1'b0;
      gap_armed     = 1'b0;
      started_at    = '0;
      gap_from      = '0;
      expected_reads.delete();
   endtask

   task automatic bump(input int slot);
      tallies[slot] = tallies[slot] + 1'b1;
   endtask

   function automatic logic [DATA_WIDTH-1:0] stat_value(input logic [INDEX_WIDTH-1:0] idx);
      if (idx == STAT_SEEN) return DATA_WIDTH'(any_recorded);
      if (idx == STAT_FREE_MIN) return DATA_WIDTH'(lowest_free);
      if (idx == STAT_READY_MAX) return DATA_WIDTH'(highest_ready);
      if (idx == STAT_LAST_TIME) return DATA_WIDTH'(last_stamp);
      if (idx >= STAT_SNAP_FREE && idx <= STAT_SNAP_GFR)
         return DATA_WIDTH'(snap[idx - STAT_SNAP_FREE]);
      if (idx >= STAT_CNT_FIRST && idx <= STAT_CNT_LAST)
         return DATA_WIDTH'(tallies[idx - STAT_CNT_FIRST]);
      if (idx >= STAT_SUM_FIRST && idx <= STAT_SUM_LAST)
         return DATA_WIDTH'(totals[idx - STAT_SUM_FIRST]);
      if (idx == STAT_LAT_MAX) return DATA_WIDTH'(worst_latency);
      if (idx == STAT_GAP_MAX) return DATA_WIDTH'(worst_gap);
      return '0;
   endfunction

   // Applies one accepted word to the copy of the statistics.
   task automatic record_event(input req_item_type w);
      logic [TIME_WIDTH-1:0] span;
      if (w.kind == KIND_READ) begin
         expected_reads.push_back(stat_value(w.counter_index));
         return;
      end
      if (w.kind > KIND_READ) return;

      if (!any_recorded || w.free_buffers < lowest_free) lowest_free = w.free_buffers;
      if (w.ready_buffers > highest_ready) highest_ready = w.ready_buffers;
      any_recorded = 1'b1;
      last_stamp   = w.time_us;
      bump(CNT_SAMPLES);
      snap[0] = w.free_buffers;
      snap[1] = w.ready_buffers;
      snap[2] = SNAP_WIDTH'(w.transfer_active);
      snap[3] = SNAP_WIDTH'(w.glue_present);
      snap[4] = w.glue_frame_count;

      case (w.kind)
         KIND_INIT: begin
            bump(CNT_INITS);
            latency_armed = 1'b0;
            gap_armed     = 1'b0;
         end
         KIND_BUSY: begin
            bump(CNT_BUSY);
            if (w.free_buffers == '0) bump(CNT_BUSY_NO_FREE);
            if (w.transfer_active) bump(CNT_BUSY_ACTIVE);
         end
         KIND_START: begin
            bump(CNT_STARTED);
            totals[SUM_BYTES_STARTED]  += SUM_WIDTH'(w.byte_count);
            totals[SUM_FRAMES_STARTED] += SUM_WIDTH'(w.frame_count);
            latency_armed = 1'b1;
            started_at    = w.time_us;
            if (gap_armed) begin
               span = w.time_us - gap_from;
               bump(CNT_GAPS);
               totals[SUM_GAP] += SUM_WIDTH'(span);
               if (span > worst_gap) worst_gap = span;
               gap_armed = 1'b0;
            end
         end
         KIND_START_ERR: bump(CNT_START_ERR);
         KIND_COMPLETE, KIND_COMPLETE_ERR: begin
            if (w.kind == KIND_COMPLETE) begin
               bump(CNT_COMPLETED);
               totals[SUM_BYTES_DONE] += SUM_WIDTH'(w.byte_count);
            end else begin
               bump(CNT_COMPLETE_ERR);
            end
            if (latency_armed) begin
               span = w.time_us - started_at;
               bump(CNT_TIMED);
               totals[SUM_LATENCY] += SUM_WIDTH'(span);
               if (span > worst_latency) worst_latency = span;
               if (span <= TIME_WIDTH'(edges.low)) bump(CNT_BUCKET0);
               else if (span <= TIME_WIDTH'(edges.mid)) bump(CNT_BUCKET1);
               else if (span <= TIME_WIDTH'(edges.high)) bump(CNT_BUCKET2);
               else bump(CNT_BUCKET3);
            end
            latency_armed = 1'b0;
            gap_armed = (w.ready_buffers != '0) || (w.glue_present && w.glue_frame_count != '0);
            gap_from  = w.time_us;
         end
         KIND_ZLP: bump(CNT_ZLP);
         KIND_ZLP_ERR: bump(CNT_ZLP_ERR);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      req_item_type          incoming;
      logic [DATA_WIDTH-1:0] want;
      if (reset) begin
         clear_stats();
      end else begin
         // A response always belongs to a read taken on an earlier edge, so it is
         // matched before this edge's word is applied.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reads.size() == 0) begin
               report("read data with no read pending", rsp_mon.read_data, '0);
            end else begin
               want = expected_reads.pop_front();
               if (rsp_mon.read_data !== want) report("read_data", rsp_mon.read_data, want);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_EDGE_LOW:  edges.low  = csr_wdata;
               CSR_EDGE_MID:  edges.mid  = csr_wdata;
               CSR_EDGE_HIGH: edges.high = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            incoming = '{kind: req_mon.kind, time_us: req_mon.time_us,
                         free_buffers: req_mon.free_buffers,
                         ready_buffers: req_mon.ready_buffers,
                         transfer_active: req_mon.transfer_active,
                         glue_present: req_mon.glue_present,
                         glue_frame_count: req_mon.glue_frame_count,
                         byte_count: req_mon.byte_count, frame_count: req_mon.frame_count,
                         counter_index: req_mon.counter_index};
            record_event(incoming);
         end
      end
      reads_outstanding <= expected_reads.size();
   end

endmodule

[tb/testbench.sv]
// Top of the testbench for the transfer latency statistics monitor: clock, reset and stimulus.
// Instantiates the block and tlsm_checker side by side and prints the verdict.
// Depends on tlsm_pkg, tlsm_req_if, tlsm_rsp_if, tlsm_checker and the block itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tlsm_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 7;
   localparam int COUNTER_WIDTH  = 32;
   localparam int HOLD_CYCLES    = 150;
   localparam int PRESSURE_WORDS = 40;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TIMEOUT_NS     = 4_000_000;

   // Kinds outside the defined set; the block must ignore them entirely.
   localparam logic [KIND_WIDTH-1:0] KIND_UNDEF_FIRST = 4'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_UNDEF_LAST  = 4'd15;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX         = '1;
   localparam logic [EDGE_WIDTH-1:0] EDGE_MAX         = '1;
   // First index past the statistics map; such reads return zero.
   localparam logic [INDEX_WIDTH-1:0] STAT_UNKNOWN    = 6'd33;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [EDGE_WIDTH-1:0]      csr_wdata;
   int                         mismatch_count;
   int                         reads_outstanding;

   tlsm_req_if req_bus ();
   tlsm_rsp_if rsp_bus ();

   transfer_latency_stats_monitor #(.COUNTER_WIDTH(COUNTER_WIDTH)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tlsm_checker #(.COUNTER_WIDTH(COUNTER_WIDTH)) stats_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .reads_outstanding (reads_outstanding)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idling controls. bursts_allowed gates everything; the other two flip now and then
   // so that some stretches run with no idling at all.
   bit bursts_allowed  = 1'b1;
   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   // Set by the stimulus to ask for one long hold-off; cleared by the receiver.
   bit hold_request    = 1'b0;

   // Bucket edges currently in the block, so that latencies can be aimed at them.
   edges_type              active_edges;
   // Microsecond time that the stimulus advances and stamps most event words with.
   logic [TIME_WIDTH-1:0]  clock_us;
   // Words that the block acts on (defined kinds only).
   int                     words_offered = 0;

   // The receiver: mostly ready, with random stall bursts and, when asked, a single
   // long hold-off that lets the block back up into its input.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic shuffle_idling();
      sender_gaps     = bursts_allowed && ($urandom_range(0, 2) != 0);
      receiver_stalls = bursts_allowed && ($urandom_range(0, 2) != 0);
   endtask

   // Offers one word and returns at the edge where it is taken. Called at a rising
   // edge; valid stays high from one word to the next unless a gap is inserted.
   task automatic offer(input req_item_type w);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.kind             <= w.kind;
      req_bus.time_us          <= w.time_us;
      req_bus.free_buffers     <= w.free_buffers;
      req_bus.ready_buffers    <= w.ready_buffers;
      req_bus.transfer_active  <= w.transfer_active;
      req_bus.glue_present     <= w.glue_present;
      req_bus.glue_frame_count <= w.glue_frame_count;
      req_bus.byte_count       <= w.byte_count;
      req_bus.frame_count      <= w.frame_count;
      req_bus.counter_index    <= w.counter_index;
      do @(posedge clock); while (!req_bus.ready);
      if (w.kind <= KIND_READ) words_offered++;
   endtask

   // Drops valid and waits until every read has been answered, then lets the last
   // word through the input register before anything else happens.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (reads_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_edges(input logic [EDGE_WIDTH-1:0] low, mid, high);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_EDGE_LOW;
      csr_wdata    <= low;
      @(posedge clock);
      csr_index    <= CSR_EDGE_MID;
      csr_wdata    <= mid;
      @(posedge clock);
      csr_index    <= CSR_EDGE_HIGH;
      csr_wdata    <= high;
      @(posedge clock);
      csr_write_en <= 1'b0;
      active_edges = '{low: low, mid: mid, high: high};
   endtask

   function automatic logic [TIME_WIDTH-1:0] random_stamp();
      return TIME_WIDTH'({$urandom, $urandom});
   endfunction

   // A word with an empty snapshot; directed words fill in only what they need.
   function automatic req_item_type quiet_word(input logic [KIND_WIDTH-1:0] kind,
                                               input logic [TIME_WIDTH-1:0] stamp);
      req_item_type w;
      w         = '0;
      w.kind    = kind;
      w.time_us = stamp;
      return w;
   endfunction

   // Random snapshot and counts. Zero free and ready counts and an empty glue block are made
   // common so that busy words with no free buffer and both ways of arming the backlog timer come up often.
   function automatic req_item_type random_word(input logic [KIND_WIDTH-1:0] kind,
                                                input logic [TIME_WIDTH-1:0] stamp);
      req_item_type w;
      w                  = quiet_word(kind, stamp);
      w.free_buffers     = ($urandom_range(0, 4) == 0) ? '0 : SNAP_WIDTH'($urandom);
      w.ready_buffers    = ($urandom_range(0, 1) == 0) ? '0 : SNAP_WIDTH'($urandom);
      w.transfer_active  = 1'($urandom_range(0, 1));
      w.glue_present     = 1'($urandom_range(0, 1));
      w.glue_frame_count = ($urandom_range(0, 1) == 0) ? '0 : SNAP_WIDTH'($urandom);
      w.byte_count       = BYTE_WIDTH'($urandom);
      w.frame_count      = BYTE_WIDTH'($urandom);
      // Most reads hit the statistics map; the rest land past its end.
      w.counter_index    = ($urandom_range(0, 5) == 0) ?
                           INDEX_WIDTH'($urandom_range(33, 63)) :
                           INDEX_WIDTH'($urandom_range(0, 32));
      return w;
   endfunction

   // Latencies cluster right at the bucket edges (one below, on, one above), with
   // the rest spread over short, long and full-width spans.
   function automatic logic [TIME_WIDTH-1:0] pick_latency();
      logic [TIME_WIDTH-1:0] edge_val;
      case ($urandom_range(0, 6))
         0: edge_val = TIME_WIDTH'(active_edges.low);
         1: edge_val = TIME_WIDTH'(active_edges.mid);
         2: edge_val = TIME_WIDTH'(active_edges.high);
         3: return TIME_WIDTH'($urandom_range(0, 30000));
         4: return TIME_WIDTH'($urandom_range(0, 1 << 25));
         5: return TIME_WIDTH'($urandom_range(0, 3));
         default: return random_stamp();
      endcase
      return edge_val + TIME_WIDTH'($urandom_range(0, 2)) - 1'b1;
   endfunction

   function automatic logic [KIND_WIDTH-1:0] filler_kind();
      case ($urandom_range(0, 5))
         0: return KIND_BUSY;
         1: return KIND_SAMPLE;
         2: return KIND_ZLP;
         3: return KIND_ZLP_ERR;
         4: return KIND_START_ERR;
         default: return KIND_READ;
      endcase
   endfunction

   // Hand-picked words: every kind, the field extremes, latencies exactly on and
   // just past the default edges, a completion with no start before it, backlog
   // armed by ready buffers and by a non-empty glue block, init disarming the
   // latency timer, time differences that wrap, undefined kinds and an unknown index.
   task automatic directed_words();
      req_item_type w;
      w = quiet_word(KIND_READ, '0);
      w.counter_index = STAT_SEEN;
      offer(w);
      w.counter_index = STAT_FREE_MIN;
      offer(w);
      w = quiet_word(KIND_INIT, 48'd10);
      w.free_buffers = '1;
      offer(w);
      w = quiet_word(KIND_BUSY, 48'd20);
      w.transfer_active = 1'b1;
      offer(w);
      w = quiet_word(KIND_BUSY, 48'd30);
      w.free_buffers = 8'd7;
      offer(w);
      w = quiet_word(KIND_START, 48'd100);
      w.byte_count  = '1;
      w.frame_count = '1;
      offer(w);
      offer(quiet_word(KIND_START_ERR, 48'd150));
      // Latency equal to the low edge, and queued ready buffers arm the backlog.
      w = quiet_word(KIND_COMPLETE, 48'd1100);
      w.byte_count    = '1;
      w.ready_buffers = 8'd3;
      offer(w);
      offer(quiet_word(KIND_START, 48'd2000));
      // One past the low edge; a full glue block arms the backlog this time.
      w = quiet_word(KIND_COMPLETE_ERR, 48'd3001);
      w.glue_present     = 1'b1;
      w.glue_frame_count = '1;
      offer(w);
      offer(quiet_word(KIND_ZLP, 48'd3100));
      offer(quiet_word(KIND_ZLP_ERR, 48'd3200));
      w = quiet_word(KIND_SAMPLE, 48'd3300);
      w.free_buffers     = '1;
      w.ready_buffers    = '1;
      w.transfer_active  = 1'b1;
      w.glue_present     = 1'b1;
      w.glue_frame_count = '1;
      offer(w);
      // Completion with no start, and a glue block with no frames leaves no backlog.
      w = quiet_word(KIND_COMPLETE, 48'd3400);
      w.glue_present = 1'b1;
      offer(w);
      offer(quiet_word(KIND_START, 48'd3500));
      offer(quiet_word(KIND_INIT, 48'd3600));
      offer(quiet_word(KIND_COMPLETE, 48'd3700));
      // Latency across the wrap of the time field, then a backlog gap that wraps.
      offer(quiet_word(KIND_START, TIME_MAX - 48'd9));
      w = quiet_word(KIND_COMPLETE, 48'd20);
      w.ready_buffers = '1;
      offer(w);
      offer(quiet_word(KIND_START, 48'd10));
      offer(quiet_word(KIND_UNDEF_FIRST, 48'd500));
      w = '1;
      w.kind = KIND_UNDEF_LAST;
      offer(w);
      offer(quiet_word(KIND_COMPLETE, 48'd25011));
      w = quiet_word(KIND_READ, TIME_MAX);
      w.counter_index = STAT_UNKNOWN;
      offer(w);
      w.counter_index = '1;
      offer(w);
   endtask

   // Mostly whole transfers (start, a few other events, a completion at a chosen
   // latency), mixed with reads, inits and words of any kind with any stamp.
   task automatic random_traffic(input int count);
      int                    goal;
      int                    pick;
      logic [TIME_WIDTH-1:0] began;
      logic [KIND_WIDTH-1:0] kind;
      goal = words_offered + count;
      while (words_offered < goal) begin
         if ($urandom_range(0, 31) == 0) shuffle_idling();
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            began = clock_us;
            offer(random_word(KIND_START, began));
            repeat ($urandom_range(0, 3)) begin
               clock_us += TIME_WIDTH'($urandom_range(0, 200));
               offer(random_word(filler_kind(), clock_us));
            end
            clock_us = began + pick_latency();
            kind = ($urandom_range(0, 4) == 0) ? KIND_COMPLETE_ERR : KIND_COMPLETE;
            offer(random_word(kind, clock_us));
         end else if (pick < 15) begin
            offer(random_word(KIND_READ, clock_us));
         end else if (pick < 16) begin
            offer(random_word(KIND_INIT, clock_us));
         end else begin
            kind = KIND_WIDTH'($urandom_range(0, 15));
            offer(random_word(kind, ($urandom_range(0, 2) == 0) ? random_stamp() : clock_us));
         end
         if ($urandom_range(0, 15) == 0) clock_us = random_stamp();
         else clock_us += TIME_WIDTH'($urandom_range(0, 3000));
      end
   endtask

   initial begin
      logic [EDGE_WIDTH-1:0] low;
      logic [EDGE_WIDTH-1:0] mid;

      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.kind             <= KIND_INIT;
      req_bus.time_us          <= '0;
      req_bus.free_buffers     <= '0;
      req_bus.ready_buffers    <= '0;
      req_bus.transfer_active  <= 1'b0;
      req_bus.glue_present     <= 1'b0;
      req_bus.glue_frame_count <= '0;
      req_bus.byte_count       <= '0;
      req_bus.frame_count      <= '0;
      req_bus.counter_index    <= STAT_SEEN;
      csr_write_en             <= 1'b0;
      csr_index                <= CSR_EDGE_LOW;
      csr_wdata                <= '0;
      active_edges = '{low: EDGE_LOW_RESET, mid: EDGE_MID_RESET, high: EDGE_HIGH_RESET};
      clock_us     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset edges: hand-picked words first, then random traffic.
      shuffle_idling();
      directed_words();
      clock_us = 48'd100_000;
      random_traffic(260);

      // Back-pressure: the receiver holds off for a long stretch while reads keep
      // coming, so read data piles up and the block has to drop req_bus.ready.
      hold_request = 1'b1;
      repeat (PRESSURE_WORDS) begin
         offer(random_word(($urandom_range(0, 3) == 0) ? KIND_SAMPLE : KIND_READ, clock_us));
      end
      drain();

      // All edges at zero: every nonzero latency falls in the last bucket.
      write_edges('0, '0, '0);
      random_traffic(250);
      drain();

      // All edges at their maximum: nearly everything lands in the first bucket.
      write_edges(EDGE_MAX, EDGE_MAX, EDGE_MAX);
      random_traffic(250);
      drain();

      // Ordered random edges.
      low = EDGE_WIDTH'($urandom_range(0, 2000));
      mid = low + EDGE_WIDTH'($urandom_range(0, 10000));
      write_edges(low, mid, mid + EDGE_WIDTH'($urandom_range(0, 100000)));
      random_traffic(300);
      drain();

      // Edges out of order: the low edge above the others hides the middle buckets.
      write_edges(EDGE_WIDTH'($urandom_range(20000, 40000)), EDGE_WIDTH'($urandom_range(0, 500)),
                  EDGE_WIDTH'($urandom_range(1000, 5000)));
      random_traffic(250);
      drain();

      // Last part runs flat out on both sides, back at the reset edge values.
      bursts_allowed = 1'b0;
      shuffle_idling();
      write_edges(EDGE_LOW_RESET, EDGE_MID_RESET, EDGE_HIGH_RESET);
      random_traffic(300);
      drain();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
sv/tlsm_pkg.sv
sv/tlsm_req_if.sv
sv/tlsm_rsp_if.sv
sv/tlsm_bucket.sv
sv/tlsm_stats.sv
sv/transfer_latency_stats_monitor.sv
tb/tlsm_checker.sv
tb/testbench.sv
